@@ rtl/its_pkg.sv @@
// Shared constants, header tables and status types of the image trailing data scanner.
`default_nettype none

package its_pkg;

    localparam logic [2:0] FMT_PNG  = 3'd0;
    localparam logic [2:0] FMT_JPEG = 3'd1;
    localparam logic [2:0] FMT_GIF  = 3'd2;
    localparam logic [2:0] FMT_BMP  = 3'd3;

    localparam logic [1:0] VERDICT_INCONCLUSIVE = 2'd0;
    localparam logic [1:0] VERDICT_CLEAN        = 2'd1;
    localparam logic [1:0] VERDICT_SUSPICIOUS   = 2'd2;
    localparam logic [1:0] VERDICT_POSITIVE     = 2'd3;

    localparam int unsigned SIG_COUNT = 6;

    localparam logic [7:0]  GIF_TRAILER    = 8'h3B;
    localparam logic [15:0] JPEG_EOI       = 16'hFFD9;
    localparam logic [31:0] PNG_IEND       = 32'h4945_4E44;
    localparam logic [3:0]  PNG_FIRST_CHUNK = 4'd8;
    localparam logic [3:0]  PNG_CHUNK_OVERHEAD = 4'd12;
    localparam logic [2:0]  PNG_TAG_LAST   = 3'd7;
    localparam logic [2:0]  BMP_SIZE_LAST  = 3'd5;
    localparam logic [2:0]  BMP_MIN_SIZE   = 3'd6;

    // Order: zip, rar, 7z, gzip, pdf, png.
    localparam logic [63:0] SIG_VALUE [SIG_COUNT] = '{
        64'h0000_0000_504B_0304,
        64'h0000_5261_7221_1A07,
        64'h0000_377A_BCAF_271C,
        64'h0000_0000_001F_8B08,
        64'h0000_0025_5044_462D,
        64'h8950_4E47_0D0A_1A0A
    };
    localparam logic [63:0] SIG_MASK [SIG_COUNT] = '{
        64'h0000_0000_FFFF_FFFF,
        64'h0000_FFFF_FFFF_FFFF,
        64'h0000_FFFF_FFFF_FFFF,
        64'h0000_0000_00FF_FFFF,
        64'h0000_00FF_FFFF_FFFF,
        64'hFFFF_FFFF_FFFF_FFFF
    };
    localparam logic [3:0] SIG_LEN [SIG_COUNT] = '{
        4'd4, 4'd6, 4'd6, 4'd3, 4'd5, 4'd8
    };

    typedef struct packed {
        logic [2:0]           fmt;
        logic                 header_ok;
        logic                 chunk_is_end;
        logic                 walk_failed;
        logic                 marker_valid;
        logic [SIG_COUNT-1:0] sig_valid;
    } t_status;

    function automatic logic fmt_supported(input logic [2:0] fmt);
        logic ok;
        case (fmt)
            FMT_PNG, FMT_JPEG, FMT_GIF, FMT_BMP: ok = 1'b1;
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic logic [3:0] hdr_len(input logic [2:0] fmt);
        logic [3:0] len;
        case (fmt)
            FMT_PNG:  len = 4'd8;
            FMT_JPEG: len = 4'd2;
            FMT_GIF:  len = 4'd4;
            FMT_BMP:  len = 4'd2;
            default:  len = 4'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] hdr_byte(input logic [2:0] fmt, input logic [2:0] idx);
        logic [63:0] magic;
        case (fmt)
            FMT_PNG:  magic = 64'h8950_4E47_0D0A_1A0A;
            FMT_JPEG: magic = 64'hFFD8_0000_0000_0000;
            FMT_GIF:  magic = 64'h4749_4638_0000_0000;
            FMT_BMP:  magic = 64'h424D_0000_0000_0000;
            default:  magic = 64'h0;
        endcase
        return magic[63 - {idx, 3'b000} -: 8];
    endfunction

endpackage

`default_nettype wire

@@ rtl/its_core.sv @@
// Input register, per-byte stream state update and end-of-file snapshot register.
`default_nettype none

module its_core #(
    parameter int unsigned OFFSET_BITS = 32
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic                                      i_cfg_we,
    input  wire logic [2:0]                                i_cfg_wdata,
    input  wire logic                                      i_valid,
    output      logic                                      o_stall,
    input  wire logic [7:0]                                i_data_byte,
    input  wire logic                                      i_final_byte,
    output      logic                                      o_snap_valid,
    input  wire logic                                      i_snap_take,
    output      its_pkg::t_status                          o_status,
    output      logic [OFFSET_BITS-1:0]                    o_size,
    output      logic [OFFSET_BITS-1:0]                    o_chunk_start,
    output      logic [OFFSET_BITS-1:0]                    o_marker_pos,
    output      logic [31:0]                               o_declared,
    output      logic [its_pkg::SIG_COUNT-1:0][OFFSET_BITS-1:0] o_sig_pos
);

    localparam int unsigned OB = OFFSET_BITS;
    localparam int unsigned WB = ((OB > 32) ? OB : 32) + 2;
    localparam int unsigned SC = its_pkg::SIG_COUNT;
    localparam logic [OB-1:0] CHUNK_FIRST = OB'(its_pkg::PNG_FIRST_CHUNK);

    logic [2:0]  r_fmt;

    logic        r_in_valid;
    logic [7:0]  r_byte;
    logic        r_final;

    logic [OB-1:0]         r_offset;
    logic [63:0]           r_recent;
    logic                  r_header_ok;
    logic [OB-1:0]         r_chunk_start;
    logic                  r_chunk_is_end;
    logic                  r_walk_failed;
    logic [OB-1:0]         r_marker_pos;
    logic                  r_marker_valid;
    logic [31:0]           r_declared;
    logic [SC-1:0][OB-1:0] r_sig_pos;
    logic [SC-1:0]         r_sig_valid;

    logic [OB-1:0]         n_offset;
    logic [63:0]           n_recent;
    logic                  n_header_ok;
    logic [OB-1:0]         n_chunk_start;
    logic                  n_chunk_is_end;
    logic                  n_walk_failed;
    logic [OB-1:0]         n_marker_pos;
    logic                  n_marker_valid;
    logic [31:0]           n_declared;
    logic [SC-1:0][OB-1:0] n_sig_pos;
    logic [SC-1:0]         n_sig_valid;

    logic                  r_snap_valid;
    its_pkg::t_status      r_status;
    logic [OB-1:0]         r_size;
    logic [OB-1:0]         r_snap_chunk;
    logic [OB-1:0]         r_snap_marker;
    logic [31:0]           r_snap_declared;
    logic [SC-1:0][OB-1:0] r_snap_sig_pos;

    logic snap_ready;
    logic s1_go;

    assign snap_ready = !r_snap_valid || i_snap_take;
    assign s1_go      = r_in_valid && (!r_final || snap_ready);
    assign o_stall    = r_in_valid && !s1_go;

    always_comb begin
        logic [OB-1:0] pos;
        logic [OB:0]   tag_pos;
        logic [WB-1:0] next_chunk;
        logic          bad_hdr;
        pos            = r_offset;
        n_offset       = (&pos) ? pos : pos + OB'(1);
        n_recent       = {r_recent[55:0], r_byte};
        n_chunk_start  = r_chunk_start;
        n_chunk_is_end = r_chunk_is_end;
        n_walk_failed  = r_walk_failed;
        n_marker_pos   = r_marker_pos;
        n_marker_valid = r_marker_valid;
        n_declared     = r_declared;
        n_sig_pos      = r_sig_pos;
        n_sig_valid    = r_sig_valid;

        bad_hdr = its_pkg::fmt_supported(r_fmt)
                  && (pos < OB'(its_pkg::hdr_len(r_fmt)))
                  && (r_byte != its_pkg::hdr_byte(r_fmt, pos[2:0]));
        n_header_ok = r_header_ok && !bad_hdr;

        tag_pos    = {1'b0, r_chunk_start} + (OB + 1)'(its_pkg::PNG_TAG_LAST);
        next_chunk = WB'(r_chunk_start) + WB'(its_pkg::PNG_CHUNK_OVERHEAD)
                     + WB'(n_recent[63:32]);

        if (r_fmt == its_pkg::FMT_PNG) begin
            if (n_header_ok && !r_chunk_is_end && !r_walk_failed
                && ({1'b0, pos} == tag_pos)) begin
                if (n_recent[31:0] == its_pkg::PNG_IEND) begin
                    n_chunk_is_end = 1'b1;
                end
                if (next_chunk > WB'({OB{1'b1}})) begin
                    n_walk_failed = 1'b1;
                end else begin
                    n_chunk_start = next_chunk[OB-1:0];
                end
            end
        end
        if (r_fmt == its_pkg::FMT_JPEG) begin
            if ((pos != '0) && (n_recent[15:0] == its_pkg::JPEG_EOI)) begin
                n_marker_pos   = n_offset;
                n_marker_valid = 1'b1;
            end
        end
        if (r_fmt == its_pkg::FMT_GIF) begin
            if (r_byte == its_pkg::GIF_TRAILER) begin
                n_marker_pos   = n_offset;
                n_marker_valid = 1'b1;
            end
        end
        if (r_fmt == its_pkg::FMT_BMP) begin
            if (pos == OB'(its_pkg::BMP_SIZE_LAST)) begin
                n_declared = {n_recent[7:0], n_recent[15:8], n_recent[23:16], n_recent[31:24]};
            end
        end

        for (int k = 0; k < SC; k++) begin
            if ((n_offset >= OB'(its_pkg::SIG_LEN[k]))
                && ((n_recent & its_pkg::SIG_MASK[k]) == its_pkg::SIG_VALUE[k])) begin
                n_sig_pos[k]   = n_offset - OB'(its_pkg::SIG_LEN[k]);
                n_sig_valid[k] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt      <= its_pkg::FMT_PNG;
            r_in_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_fmt <= i_cfg_wdata;
            end
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_byte  <= i_data_byte;
            r_final <= i_final_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (s1_go && r_final)) begin
            r_offset       <= '0;
            r_recent       <= '0;
            r_header_ok    <= 1'b1;
            r_chunk_start  <= CHUNK_FIRST;
            r_chunk_is_end <= 1'b0;
            r_walk_failed  <= 1'b0;
            r_marker_pos   <= '0;
            r_marker_valid <= 1'b0;
            r_declared     <= '0;
            r_sig_pos      <= '0;
            r_sig_valid    <= '0;
        end else if (s1_go) begin
            r_offset       <= n_offset;
            r_recent       <= n_recent;
            r_header_ok    <= n_header_ok;
            r_chunk_start  <= n_chunk_start;
            r_chunk_is_end <= n_chunk_is_end;
            r_walk_failed  <= n_walk_failed;
            r_marker_pos   <= n_marker_pos;
            r_marker_valid <= n_marker_valid;
            r_declared     <= n_declared;
            r_sig_pos      <= n_sig_pos;
            r_sig_valid    <= n_sig_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (s1_go && r_final) begin
            r_snap_valid <= 1'b1;
        end else if (i_snap_take) begin
            r_snap_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_final) begin
            r_status.fmt          <= r_fmt;
            r_status.header_ok    <= n_header_ok;
            r_status.chunk_is_end <= n_chunk_is_end;
            r_status.walk_failed  <= n_walk_failed;
            r_status.marker_valid <= n_marker_valid;
            r_status.sig_valid    <= n_sig_valid;
            r_size                <= n_offset;
            r_snap_chunk          <= n_chunk_start;
            r_snap_marker         <= n_marker_pos;
            r_snap_declared       <= n_declared;
            r_snap_sig_pos        <= n_sig_pos;
        end
    end

    assign o_snap_valid  = r_snap_valid;
    assign o_status      = r_status;
    assign o_size        = r_size;
    assign o_chunk_start = r_snap_chunk;
    assign o_marker_pos  = r_snap_marker;
    assign o_declared    = r_snap_declared;
    assign o_sig_pos     = r_snap_sig_pos;

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go && r_final |=> (r_offset == '0) && r_header_ok && (r_sig_valid == '0))
        else $error("stream state not cleared after the last byte of a file");

    a_offset_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go && !r_final && !(&r_offset) |=> r_offset == $past(r_offset) + OB'(1))
        else $error("byte offset did not advance by one");

    a_snap_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_snap_valid && !i_snap_take |=> r_snap_valid && $stable(r_size))
        else $error("pending end-of-file snapshot was lost or changed");

endmodule

`default_nettype wire

@@ rtl/its_verdict.sv @@
// Verdict, end offset, trailing count and signature mask, with the result register.
`default_nettype none

module its_verdict #(
    parameter int unsigned OFFSET_BITS = 32
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic                                      i_snap_valid,
    output      logic                                      o_snap_take,
    input  wire its_pkg::t_status                          i_status,
    input  wire logic [OFFSET_BITS-1:0]                    i_size,
    input  wire logic [OFFSET_BITS-1:0]                    i_chunk_start,
    input  wire logic [OFFSET_BITS-1:0]                    i_marker_pos,
    input  wire logic [31:0]                               i_declared,
    input  wire logic [its_pkg::SIG_COUNT-1:0][OFFSET_BITS-1:0] i_sig_pos,
    output      logic                                      o_valid,
    input  wire logic                                      i_stall,
    output      logic [1:0]                                o_verdict,
    output      logic [31:0]                               o_end_offset,
    output      logic [31:0]                               o_trailing_count,
    output      logic [5:0]                                o_signature_mask
);

    localparam int unsigned OB = OFFSET_BITS;
    localparam int unsigned WB = ((OB > 32) ? OB : 32) + 2;
    localparam int unsigned SC = its_pkg::SIG_COUNT;
    localparam logic [WB-1:0] OUT_MAX = WB'(32'hFFFF_FFFF);

    logic        r_out_valid;
    logic [1:0]  r_verdict;
    logic [31:0] r_end;
    logic [31:0] r_trailing;
    logic [5:0]  r_mask;

    logic [1:0]  n_verdict;
    logic [31:0] n_end;
    logic [31:0] n_trailing;
    logic [5:0]  n_mask;

    logic take;

    assign take        = !r_out_valid || !i_stall;
    assign o_snap_take = take;

    always_comb begin
        logic [WB-1:0] size_w;
        logic [WB-1:0] end_w;
        logic [WB-1:0] trail_w;
        logic          have_end;
        logic          hdr_fine;
        logic [SC-1:0] found;
        size_w   = WB'(i_size);
        end_w    = '0;
        have_end = 1'b0;
        hdr_fine = its_pkg::fmt_supported(i_status.fmt) && i_status.header_ok
                   && (size_w >= WB'(its_pkg::hdr_len(i_status.fmt)));
        case (i_status.fmt)
            its_pkg::FMT_PNG: begin
                end_w    = WB'(i_chunk_start);
                have_end = i_status.chunk_is_end && !i_status.walk_failed
                           && (end_w <= size_w);
            end
            its_pkg::FMT_JPEG, its_pkg::FMT_GIF: begin
                end_w    = WB'(i_marker_pos);
                have_end = i_status.marker_valid;
            end
            its_pkg::FMT_BMP: begin
                end_w    = WB'(i_declared);
                have_end = (size_w >= WB'(its_pkg::BMP_MIN_SIZE)) && (end_w <= size_w);
            end
            default: begin
                end_w    = '0;
                have_end = 1'b0;
            end
        endcase
        trail_w = size_w - end_w;
        for (int k = 0; k < SC; k++) begin
            found[k] = i_status.sig_valid[k] && (WB'(i_sig_pos[k]) >= end_w);
        end

        n_verdict  = its_pkg::VERDICT_INCONCLUSIVE;
        n_end      = '0;
        n_trailing = '0;
        n_mask     = '0;
        if (hdr_fine && have_end && (end_w <= size_w)) begin
            n_end      = (end_w > OUT_MAX) ? 32'hFFFF_FFFF : end_w[31:0];
            n_trailing = (trail_w > OUT_MAX) ? 32'hFFFF_FFFF : trail_w[31:0];
            if (trail_w == '0) begin
                n_verdict = its_pkg::VERDICT_CLEAN;
            end else begin
                n_mask    = 6'(found);
                n_verdict = (found != '0) ? its_pkg::VERDICT_POSITIVE
                                          : its_pkg::VERDICT_SUSPICIOUS;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= i_snap_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_snap_valid) begin
            r_verdict  <= n_verdict;
            r_end      <= n_end;
            r_trailing <= n_trailing;
            r_mask     <= n_mask;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_verdict        = r_verdict;
    assign o_end_offset     = r_end;
    assign o_trailing_count = r_trailing;
    assign o_signature_mask = r_mask;

    a_clean_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_verdict == its_pkg::VERDICT_CLEAN)
        |-> (r_trailing == '0) && (r_mask == '0))
        else $error("clean result with trailing bytes or signatures");

    a_inconclusive_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_verdict == its_pkg::VERDICT_INCONCLUSIVE)
        |-> (r_end == '0) && (r_trailing == '0) && (r_mask == '0))
        else $error("inconclusive result carries an offset or mask");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_stall
        |=> r_out_valid && $stable(r_verdict) && $stable(r_end) && $stable(r_trailing))
        else $error("stalled result was lost or changed");

endmodule

`default_nettype wire

@@ rtl/image_trailing_data_scanner.sv @@
// Top level of the image trailing data scanner.
//
//   Channel   Direction  Handshake            Payload
//   config    in         i_cfg_we             i_cfg_wdata (image format)
//   byte      in         i_valid / o_stall    i_data_byte, i_final_byte
//   result    out        o_valid / i_stall    o_verdict, o_end_offset,
//                                             o_trailing_count, o_signature_mask
//
// One byte is accepted per cycle while o_stall is low; after the last byte of a file is accepted,
// its result passes from the input register through the snapshot and verdict registers to the output.
// Reset is synchronous; it sets the format to PNG and clears the stream state at once.
// While a result waits under i_stall, bytes of the next file keep flowing; o_stall
// rises only when a further last byte cannot move into the full snapshot register.
`default_nettype none

module image_trailing_data_scanner #(
    parameter int unsigned OFFSET_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_wdata,
    input  wire logic        i_valid,
    output      logic        o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_final_byte,
    output      logic        o_valid,
    input  wire logic        i_stall,
    output      logic [1:0]  o_verdict,
    output      logic [31:0] o_end_offset,
    output      logic [31:0] o_trailing_count,
    output      logic [5:0]  o_signature_mask
);

    logic                                           snap_valid;
    logic                                           snap_take;
    its_pkg::t_status                               snap_status;
    logic [OFFSET_BITS-1:0]                         snap_size;
    logic [OFFSET_BITS-1:0]                         snap_chunk;
    logic [OFFSET_BITS-1:0]                         snap_marker;
    logic [31:0]                                    snap_declared;
    logic [its_pkg::SIG_COUNT-1:0][OFFSET_BITS-1:0] snap_sig_pos;

    its_core #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data_byte   (i_data_byte),
        .i_final_byte  (i_final_byte),
        .o_snap_valid  (snap_valid),
        .i_snap_take   (snap_take),
        .o_status      (snap_status),
        .o_size        (snap_size),
        .o_chunk_start (snap_chunk),
        .o_marker_pos  (snap_marker),
        .o_declared    (snap_declared),
        .o_sig_pos     (snap_sig_pos)
    );

    its_verdict #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_verdict (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_snap_valid     (snap_valid),
        .o_snap_take      (snap_take),
        .i_status         (snap_status),
        .i_size           (snap_size),
        .i_chunk_start    (snap_chunk),
        .i_marker_pos     (snap_marker),
        .i_declared       (snap_declared),
        .i_sig_pos        (snap_sig_pos),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_verdict        (o_verdict),
        .o_end_offset     (o_end_offset),
        .o_trailing_count (o_trailing_count),
        .o_signature_mask (o_signature_mask)
    );

endmodule

`default_nettype wire
